[hdl/tcpq_pkg.sv]
// Shared types, codes and constants of the two-class priority queue.
package tcpq_pkg;

  localparam logic       KIND_INSERT  = 1'b0;
  localparam logic       KIND_EXTRACT = 1'b1;
  localparam logic [3:0] THRESH_RESET = 4'd6;
  localparam int         CountWidth   = 10;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_REMOVED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } tcpq_status_e;

  typedef struct packed {
    logic [3:0]  key;
    logic [15:0] payload;
  } tcpq_entry_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  priority_req;
    logic [15:0] ticket_id;
  } tcpq_in_t;

  typedef struct packed {
    tcpq_status_e          status;
    logic [15:0]           out_ticket;
    logic [3:0]            out_priority;
    logic                  from_heap;
    logic [CountWidth-1:0] waiting_count;
  } tcpq_res_t;

  typedef struct packed {
    logic ins;
    logic ext;
  } tcpq_heap_cmd_t;

  typedef struct packed {
    logic        done;
    tcpq_entry_t top;
  } tcpq_heap_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } tcpq_fifo_cmd_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_UP,
    H_UP_CMP,
    H_TOP,
    H_LAST,
    H_DN,
    H_DN_L,
    H_DN_R
  } tcpq_heap_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_HEAP,
    T_FIFO
  } tcpq_top_state_e;

endpackage

[hdl/tcpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tcpq_fifo.sv]
// Ring buffer for entries below the class threshold.
module tcpq_fifo import tcpq_pkg::*; #(
  parameter int Depth = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcpq_fifo_cmd_t             cmd_i,
  input  tcpq_entry_t                entry_i,
  output tcpq_entry_t                entry_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int AW = $clog2(Depth);
  localparam int SW = $clog2(Depth + 1);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [SW-1:0] size_q, size_d;
  logic [$bits(tcpq_entry_t)-1:0] rdata;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    size_d = size_q;
    if (cmd_i.push) begin
      tail_d = wrap_next(tail_q);
      size_d = size_q + SW'(1);
    end else if (cmd_i.pop) begin
      head_d = wrap_next(head_q);
      size_d = size_q - SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      size_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      size_q <= size_d;
    end
  end

  tcpq_ram #(
    .Width($bits(tcpq_entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(tail_q),
    .wdata_i(entry_i),
    .raddr_i(head_q),
    .rdata_o(rdata)
  );

  assign entry_o = tcpq_entry_t'(rdata);
  assign count_o = size_q;

endmodule

[hdl/tcpq_heap.sv]
// Binary max-heap with an iterative sift-up/sift-down sequencer over one RAM.
module tcpq_heap import tcpq_pkg::*; #(
  parameter int Depth = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcpq_heap_cmd_t             cmd_i,
  input  tcpq_entry_t                entry_i,
  output tcpq_heap_stat_t            stat_o,
  output logic [$clog2(Depth+1)-1:0] size_o
);

  localparam int AW = $clog2(Depth);
  localparam int SW = $clog2(Depth + 1);
  localparam int CW = AW + 2;

  tcpq_heap_state_e state_q, state_d;
  logic [AW-1:0] pos_q, pos_d, best_q, best_d;
  logic [SW-1:0] size_q, size_d;
  tcpq_entry_t   mov_q, mov_d, top_q, top_d, bk_q, bk_d;

  logic [$bits(tcpq_entry_t)-1:0] rdata;
  tcpq_entry_t   rd_ent;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  tcpq_entry_t   wdata;
  logic          done;

  logic [CW-1:0] l_idx, r_idx;
  logic          l_ok, r_ok;
  logic [AW-1:0] pos_m1, parent;
  logic [SW-1:0] size_m1;
  logic [3:0]    cmp_a, cmp_b;
  logic          gt;
  logic [AW-1:0] cand_idx;
  tcpq_entry_t   cand_ent;

  assign rd_ent  = tcpq_entry_t'(rdata);
  assign l_idx   = {1'b0, pos_q, 1'b1};
  assign r_idx   = l_idx + CW'(1);
  assign l_ok    = l_idx < CW'(size_q);
  assign r_ok    = r_idx < CW'(size_q);
  assign pos_m1  = pos_q - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign size_m1 = size_q - SW'(1);

  // The one key comparator, shared by both sift directions.
  always_comb begin
    unique case (state_q)
      H_UP_CMP: begin
        cmp_a = mov_q.key;
        cmp_b = rd_ent.key;
      end
      H_DN_R: begin
        cmp_a = rd_ent.key;
        cmp_b = bk_q.key;
      end
      default: begin
        cmp_a = rd_ent.key;
        cmp_b = mov_q.key;
      end
    endcase
  end
  assign gt = cmp_a > cmp_b;

  // Best slot so far among the hole and its children; left wins ties.
  always_comb begin
    if (state_q == H_DN_R) begin
      cand_idx = gt ? r_idx[AW-1:0] : best_q;
      cand_ent = gt ? rd_ent : bk_q;
    end else begin
      cand_idx = gt ? l_idx[AW-1:0] : pos_q;
      cand_ent = gt ? rd_ent : mov_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      H_IDLE: begin
        if (cmd_i.ins) begin
          state_d = H_UP;
        end else if (cmd_i.ext) begin
          state_d = H_TOP;
        end
      end
      H_UP:     state_d = (pos_q == '0) ? H_IDLE : H_UP_CMP;
      H_UP_CMP: state_d = gt ? H_UP : H_IDLE;
      H_TOP:    state_d = H_LAST;
      H_LAST:   state_d = (size_q == '0) ? H_IDLE : H_DN;
      H_DN:     state_d = l_ok ? H_DN_L : H_IDLE;
      H_DN_L: begin
        if (r_ok) begin
          state_d = H_DN_R;
        end else begin
          state_d = (cand_idx == pos_q) ? H_IDLE : H_DN;
        end
      end
      H_DN_R:   state_d = (cand_idx == pos_q) ? H_IDLE : H_DN;
      default:  state_d = H_IDLE;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    waddr  = pos_q;
    wdata  = mov_q;
    raddr  = '0;
    done   = 1'b0;
    pos_d  = pos_q;
    size_d = size_q;
    mov_d  = mov_q;
    top_d  = top_q;
    best_d = best_q;
    bk_d   = bk_q;
    unique case (state_q)
      H_IDLE: begin
        if (cmd_i.ins) begin
          pos_d  = size_q[AW-1:0];
          mov_d  = entry_i;
          size_d = size_q + SW'(1);
        end
      end
      H_UP: begin
        if (pos_q == '0) begin
          we   = 1'b1;
          done = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (gt) begin
          wdata = rd_ent;
          pos_d = parent;
        end else begin
          done = 1'b1;
        end
      end
      H_TOP: begin
        top_d  = rd_ent;
        raddr  = size_m1[AW-1:0];
        size_d = size_m1;
      end
      H_LAST: begin
        mov_d = rd_ent;
        pos_d = '0;
        if (size_q == '0) begin
          done = 1'b1;
        end
      end
      H_DN: begin
        if (l_ok) begin
          raddr = l_idx[AW-1:0];
        end else begin
          we   = 1'b1;
          done = 1'b1;
        end
      end
      H_DN_L, H_DN_R: begin
        best_d = cand_idx;
        bk_d   = cand_ent;
        if (state_q == H_DN_L && r_ok) begin
          raddr = r_idx[AW-1:0];
        end else if (cand_idx == pos_q) begin
          we   = 1'b1;
          done = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = cand_ent;
          pos_d = cand_idx;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    mov_q  <= mov_d;
    top_q  <= top_d;
    best_q <= best_d;
    bk_q   <= bk_d;
  end

  tcpq_ram #(
    .Width($bits(tcpq_entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.done = done;
  assign stat_o.top  = top_q;
  assign size_o      = size_q;

endmodule

[hdl/two_class_priority_queue.sv]
// Top level of the two-class priority queue: command decode, class routing and result beat.
// Heap insert: the new entry climbs level by level until it reaches the root or its parent
// is not smaller. Heap extract: the root is taken and the last entry, unless it was the
// last one, sinks from the root until it is a leaf or no child is larger, with the children
// read one at a time through the single heap RAM read port. A FIFO step needs no sift.
// One item at a time, the receiver cannot stall; reset empties both stores and sets 6.
module two_class_priority_queue import tcpq_pkg::*; #(
  parameter int HEAP_DEPTH = 256,
  parameter int FIFO_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  tcpq_in_t   in_i,
  output logic       done_o,
  output tcpq_res_t  res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  localparam int HSW = $clog2(HEAP_DEPTH + 1);
  localparam int FSW = $clog2(FIFO_DEPTH + 1);

  tcpq_top_state_e state_q, state_d;
  logic [3:0]      thresh_q;
  logic            done_q, done_d;
  tcpq_res_t       res_q, res_d;
  logic            kind_q, kind_d;

  tcpq_heap_cmd_t  heap_cmd;
  tcpq_heap_stat_t heap_stat;
  logic [HSW-1:0]  heap_cnt;
  tcpq_fifo_cmd_t  fifo_cmd;
  tcpq_entry_t     fifo_ent;
  logic [FSW-1:0]  fifo_cnt;
  tcpq_entry_t     new_ent;

  logic        accept;
  logic        to_heap;
  logic        heap_full, fifo_full;
  logic        go_heap, go_fifo;
  logic [31:0] cnt_sum;

  // A beat is taken only while idle; config writes are always welcome.
  assign busy        = (state_q != T_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign new_ent.key     = in_i.priority_req;
  assign new_ent.payload = in_i.ticket_id;

  assign to_heap   = (in_i.priority_req >= thresh_q);
  assign heap_full = (heap_cnt == HSW'(HEAP_DEPTH));
  assign fifo_full = (fifo_cnt == FSW'(FIFO_DEPTH));

  // Route the accepted beat. An insert goes to its class store unless that store is full;
  // an extract drains the heap first and the FIFO only once the heap is empty.
  always_comb begin
    go_heap = 1'b0;
    go_fifo = 1'b0;
    if (accept) begin
      if (in_i.kind == KIND_INSERT) begin
        go_heap = to_heap && !heap_full;
        go_fifo = !to_heap && !fifo_full;
      end else begin
        go_heap = (heap_cnt != '0);
        go_fifo = (heap_cnt == '0) && (fifo_cnt != '0);
      end
    end
  end

  assign heap_cmd.ins  = go_heap && (in_i.kind == KIND_INSERT);
  assign heap_cmd.ext  = go_heap && (in_i.kind == KIND_EXTRACT);
  assign fifo_cmd.push = go_fifo && (in_i.kind == KIND_INSERT);
  assign fifo_cmd.pop  = go_fifo && (in_i.kind == KIND_EXTRACT);

  // Counters already reflect the step by the time any result is formed.
  assign cnt_sum = 32'(heap_cnt) + 32'(fifo_cnt);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (go_heap) begin
          state_d = T_HEAP;
        end else if (go_fifo) begin
          state_d = T_FIFO;
        end
      end
      T_HEAP:  state_d = heap_stat.done ? T_IDLE : T_HEAP;
      T_FIFO:  state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    res_d  = res_q;
    kind_d = kind_q;
    res_d.waiting_count = cnt_sum[CountWidth-1:0];
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          kind_d = in_i.kind;
          // A full store or an empty queue answers without touching either store.
          if (!go_heap && !go_fifo) begin
            done_d             = 1'b1;
            res_d.status       = (in_i.kind == KIND_INSERT) ? STATUS_FULL : STATUS_EMPTY;
            res_d.out_ticket   = '0;
            res_d.out_priority = '0;
            res_d.from_heap    = 1'b0;
          end
        end
      end
      T_HEAP: begin
        if (heap_stat.done) begin
          done_d = 1'b1;
          if (kind_q == KIND_EXTRACT) begin
            res_d.status       = STATUS_REMOVED;
            res_d.out_ticket   = heap_stat.top.payload;
            res_d.out_priority = heap_stat.top.key;
            res_d.from_heap    = 1'b1;
          end else begin
            res_d.status       = STATUS_INSERTED;
            res_d.out_ticket   = '0;
            res_d.out_priority = '0;
            res_d.from_heap    = 1'b0;
          end
        end
      end
      T_FIFO: begin
        done_d          = 1'b1;
        res_d.from_heap = 1'b0;
        if (kind_q == KIND_EXTRACT) begin
          res_d.status       = STATUS_REMOVED;
          res_d.out_ticket   = fifo_ent.payload;
          res_d.out_priority = fifo_ent.key;
        end else begin
          res_d.status       = STATUS_INSERTED;
          res_d.out_ticket   = '0;
          res_d.out_priority = '0;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      done_q   <= 1'b0;
      thresh_q <= THRESH_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    kind_q <= kind_d;
  end

  tcpq_heap #(
    .Depth(HEAP_DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (heap_cmd),
    .entry_i(new_ent),
    .stat_o (heap_stat),
    .size_o (heap_cnt)
  );

  tcpq_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fifo_cmd),
    .entry_i(new_ent),
    .entry_o(fifo_ent),
    .count_o(fifo_cnt)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
